### design/msalu_pkg.sv
`timescale 1ns / 1ps
package msalu_pkg;

  typedef enum logic [4:0] {
    OP_CMP = 5'd0, OP_EQ = 5'd1, OP_NE = 5'd2, OP_LT = 5'd3, OP_LE = 5'd4,
    OP_GT = 5'd5, OP_GE = 5'd6, OP_ADD = 5'd7, OP_SUB = 5'd8, OP_MUL = 5'd9,
    OP_DIV = 5'd10, OP_MOD = 5'd11, OP_POW = 5'd12, OP_AND = 5'd13,
    OP_OR = 5'd14, OP_XOR = 5'd15, OP_SHL = 5'd16, OP_SHR = 5'd17
  } op_e;

  localparam logic [2:0] T_UNS  = 3'd0;
  localparam logic [2:0] T_SGN  = 3'd1;
  localparam logic [2:0] T_BOOL = 3'd2;
  localparam logic [2:0] T_ERR  = 3'd3;
  localparam logic [2:0] T_FLT  = 3'd4;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] left_operand;
    logic [31:0] right_operand;
    logic        right_is_signed;
  } req_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic [2:0]  result_type;
    logic        error_code;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ITER, ST_FINISH, ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_iter;
    logic iter_done;
  } sts_t;

endpackage

### design/msalu_ctrl.sv
`timescale 1ns / 1ps
module msalu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output msalu_pkg::cmd_t   cmd_o,
  input  msalu_pkg::sts_t   sts_i
);

  msalu_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= msalu_pkg::ST_IDLE;
    else state_q <= state_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      msalu_pkg::ST_IDLE:   if (in_valid_i) state_d = msalu_pkg::ST_LOAD;
      msalu_pkg::ST_LOAD:   state_d = sts_i.need_iter ? msalu_pkg::ST_ITER
                                                      : msalu_pkg::ST_FINISH;
      msalu_pkg::ST_ITER:   if (sts_i.iter_done) state_d = msalu_pkg::ST_FINISH;
      msalu_pkg::ST_FINISH: state_d = msalu_pkg::ST_OUT;
      msalu_pkg::ST_OUT:    if (!out_stall_i) state_d = msalu_pkg::ST_IDLE;
      default:              state_d = msalu_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o  = (state_q != msalu_pkg::ST_IDLE);
    out_valid_o = (state_q == msalu_pkg::ST_OUT);
    cmd_o.load   = (state_q == msalu_pkg::ST_IDLE) && in_valid_i;
    cmd_o.step   = (state_q == msalu_pkg::ST_ITER);
    cmd_o.finish = (state_q == msalu_pkg::ST_FINISH);
  end

endmodule

### design/msalu_dp.sv
`timescale 1ns / 1ps
module msalu_dp #(
  parameter int WIDTH = 32
) (
  input  logic             clk_i,
  input  msalu_pkg::req_t  req_i,
  input  msalu_pkg::cmd_t  cmd_i,
  output msalu_pkg::sts_t  sts_o,
  output msalu_pkg::rsp_t  rsp_o
);

  localparam int SBIT = (WIDTH <= 32) ? WIDTH - 1 : 31;
  localparam int CW   = $clog2(WIDTH + 1);
  localparam int AW   = (WIDTH < 32) ? WIDTH : 32;

  // captured operands
  logic [4:0]       kind_q;
  logic [WIDTH-1:0] a_q, b_q, mag_q;
  logic             neg_q;

  // iteration registers
  logic [WIDTH-1:0] acc_q, base_q, rem_q, quo_q, e_q;
  logic [CW-1:0]    cnt_q;

  msalu_pkg::rsp_t  rsp_q;

  // final result terms
  msalu_pkg::rsp_t  fin;
  logic [WIDTH-1:0] v, sum, dif, sh_amt;
  logic             lt, gt;

  logic [WIDTH-1:0] a_in, b_in, bext;
  logic             neg_in;
  logic [31:0]      braw_ext;

  // operand decode
  always_comb begin
    a_in     = WIDTH'(req_i.left_operand[AW-1:0]);
    neg_in   = req_i.right_is_signed & req_i.right_operand[SBIT];
    braw_ext = req_i.right_operand;
    bext     = WIDTH'($signed(req_i.right_operand));
    if (!neg_in) b_in = WIDTH'(braw_ext[AW-1:0]);
    else if (WIDTH > 32) b_in = bext;
    else b_in = WIDTH'(braw_ext[AW-1:0]);
  end

  logic is_div, is_pow;
  assign is_div = (kind_q == msalu_pkg::OP_DIV) || (kind_q == msalu_pkg::OP_MOD);
  assign is_pow = (kind_q == msalu_pkg::OP_POW) && !neg_q;
  assign sts_o.need_iter = (is_div && (neg_q ? mag_q != '0 : b_q != '0)) || is_pow;
  assign sts_o.iter_done = is_pow ? (e_q == '0) : (cnt_q == CW'(1));

  // restoring divide step
  logic [WIDTH-1:0] dvs;
  logic [WIDTH:0]   trial, rsh;
  assign dvs   = neg_q ? mag_q : b_q;
  assign rsh   = {rem_q, quo_q[WIDTH-1]};
  assign trial = rsh - {1'b0, dvs};

  // one multiplier shared by the power loop and mul
  logic [WIDTH-1:0] mx, my, mp;
  always_comb begin
    if (cmd_i.step && is_pow && e_q[0]) begin
      mx = acc_q; my = base_q;
    end else if (cmd_i.step && is_pow) begin
      mx = base_q; my = base_q;
    end else begin
      mx = a_q; my = b_q;
    end
  end
  assign mp = WIDTH'(mx * my);

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= req_i.kind;
      a_q    <= a_in;
      b_q    <= b_in;
      neg_q  <= neg_in;
      mag_q  <= WIDTH'(-b_in);
    end
    if (cmd_i.load) begin
      acc_q  <= WIDTH'(1);
      base_q <= a_in;
      e_q    <= b_in;
      rem_q  <= '0;
      quo_q  <= a_in;
      cnt_q  <= CW'(WIDTH);
    end else if (cmd_i.step) begin
      if (is_pow) begin
        // odd exponent: multiply into acc; even: square base
        if (e_q[0]) begin
          acc_q <= mp;
          e_q   <= e_q ^ WIDTH'(1);
        end else begin
          base_q <= mp;
          e_q    <= e_q >> 1;
        end
      end else begin
        if (!trial[WIDTH]) begin
          rem_q <= trial[WIDTH-1:0];
          quo_q <= {quo_q[WIDTH-2:0], 1'b1};
        end else begin
          rem_q <= rsh[WIDTH-1:0];
          quo_q <= {quo_q[WIDTH-2:0], 1'b0};
        end
        cnt_q <= cnt_q - CW'(1);
      end
    end
    if (cmd_i.finish) rsp_q <= fin;
  end

  // final result select
  always_comb begin
    sum = a_q + b_q;
    dif = a_q - b_q;
    lt  = a_q < b_q;
    gt  = a_q > b_q;
    sh_amt = neg_q ? mag_q : b_q;
    v = '0;
    fin.result_type = msalu_pkg::T_UNS;
    fin.error_code  = 1'b0;
    case (kind_q)
      msalu_pkg::OP_CMP: begin
        if (neg_q) v = WIDTH'(1);
        else if (lt) begin v = '1; fin.result_type = msalu_pkg::T_SGN; end
        else v = WIDTH'(gt);
      end
      msalu_pkg::OP_EQ: begin
        v = WIDTH'(!neg_q && a_q == b_q); fin.result_type = msalu_pkg::T_BOOL;
      end
      msalu_pkg::OP_NE: begin
        v = WIDTH'(neg_q || a_q != b_q); fin.result_type = msalu_pkg::T_BOOL;
      end
      msalu_pkg::OP_LT: begin
        v = WIDTH'(!neg_q && lt); fin.result_type = msalu_pkg::T_BOOL;
      end
      msalu_pkg::OP_LE: begin
        v = WIDTH'(!neg_q && !gt); fin.result_type = msalu_pkg::T_BOOL;
      end
      msalu_pkg::OP_GT: begin
        v = WIDTH'(neg_q || gt); fin.result_type = msalu_pkg::T_BOOL;
      end
      msalu_pkg::OP_GE: begin
        v = WIDTH'(neg_q || !lt); fin.result_type = msalu_pkg::T_BOOL;
      end
      msalu_pkg::OP_ADD: begin
        v = sum;
        if (neg_q && !(a_q > mag_q)) fin.result_type = msalu_pkg::T_SGN;
      end
      msalu_pkg::OP_SUB: begin
        v = dif;
        if (!neg_q && lt) fin.result_type = msalu_pkg::T_SGN;
      end
      msalu_pkg::OP_MUL: begin
        v = mp;
        if (neg_q) fin.result_type = msalu_pkg::T_SGN;
      end
      msalu_pkg::OP_DIV, msalu_pkg::OP_MOD: begin
        if (!neg_q && b_q == '0) begin
          fin.result_type = msalu_pkg::T_ERR; fin.error_code = 1'b1;
        end else if (!neg_q) begin
          v = (kind_q == msalu_pkg::OP_DIV) ? quo_q : rem_q;
        end else begin
          fin.result_type = msalu_pkg::T_SGN;
          if (kind_q == msalu_pkg::OP_DIV) v = WIDTH'(-quo_q);
          else v = (rem_q == '0) ? '0 : WIDTH'(rem_q + b_q);
        end
      end
      msalu_pkg::OP_POW: begin
        if (!neg_q) v = acc_q;
        else if (a_q == '0) begin
          fin.result_type = msalu_pkg::T_ERR; fin.error_code = 1'b1;
        end else fin.result_type = msalu_pkg::T_FLT;
      end
      msalu_pkg::OP_AND: v = a_q & b_q;
      msalu_pkg::OP_OR:  v = a_q | b_q;
      msalu_pkg::OP_XOR: v = a_q ^ b_q;
      msalu_pkg::OP_SHL, msalu_pkg::OP_SHR: begin
        if (sh_amt >= WIDTH'(WIDTH)) v = '0;
        else if ((kind_q == msalu_pkg::OP_SHL) != neg_q) v = a_q << sh_amt;
        else v = a_q >> sh_amt;
      end
      default: fin.result_type = msalu_pkg::T_ERR;
    endcase
    fin.result_value = 32'(v);
  end

  assign rsp_o = rsp_q;

endmodule

### design/unsigned_mixed_sign_alu.sv
`timescale 1ns / 1ps
// Mixed-sign integer ALU. One transaction at a time: logic, compare, add, sub,
// mul and shift go from LOAD straight to FINISH; div and mod run a
// restoring divider one quotient bit per cycle in ITER; pow runs
// square-and-multiply on one shared multiplier, one multiply per cycle in
// ITER. The result is registered in FINISH and shown in OUT. The input is
// stalled until the result is taken, and the next transaction can be
// accepted in the cycle after that.
module unsigned_mixed_sign_alu #(
  parameter int WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  msalu_pkg::req_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output msalu_pkg::rsp_t  out_data_o
);

  msalu_pkg::cmd_t cmd;
  msalu_pkg::sts_t sts;

  msalu_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  msalu_dp #(.WIDTH(WIDTH)) u_dp (
    .clk_i, .req_i(in_data_i), .cmd_i(cmd), .sts_o(sts), .rsp_o(out_data_o)
  );

endmodule

### verif/unsigned_mixed_sign_alu_test.sv
`timescale 1ns / 1ps
module unsigned_mixed_sign_alu_test;

  localparam int WIDTH = 32;
  localparam int N_RANDOM = 600;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  msalu_pkg::req_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  msalu_pkg::rsp_t out_data_o;

  unsigned_mixed_sign_alu #(.WIDTH(WIDTH)) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  // directed row: has_rsp marks a typed-in expectation
  typedef struct {
    msalu_pkg::req_t req;
    logic has_rsp;
    msalu_pkg::rsp_t rsp;
  } row_t;

  msalu_pkg::rsp_t pending_results[$];
  int mismatch_count;
  int result_count;
  int send_idle_pct;
  int recv_stall_pct;
  logic done_sending;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #100ms;
    $display("timeout");
    $display("Some tests failed");
    $finish;
  end

  // alu behavior at WIDTH 32
  function automatic msalu_pkg::rsp_t alu_result(msalu_pkg::req_t r);
    logic [31:0] a, b, mag, acc, base, e, rem;
    logic neg;
    msalu_pkg::rsp_t o;
    a = r.left_operand;
    b = r.right_operand;
    neg = r.right_is_signed && b[31];
    mag = -b;
    o.result_value = '0;
    o.result_type = msalu_pkg::T_UNS;
    o.error_code = 1'b0;
    if (r.kind > msalu_pkg::OP_SHR) begin
      o.result_type = msalu_pkg::T_ERR;
      return o;
    end
    if (!neg) begin
      case (msalu_pkg::op_e'(r.kind))
        msalu_pkg::OP_CMP: begin
          if (a < b) begin
            o.result_value = '1;
            o.result_type = msalu_pkg::T_SGN;
          end else o.result_value = 32'(a > b);
        end
        msalu_pkg::OP_EQ: begin
          o.result_value = 32'(a == b); o.result_type = msalu_pkg::T_BOOL;
        end
        msalu_pkg::OP_NE: begin
          o.result_value = 32'(a != b); o.result_type = msalu_pkg::T_BOOL;
        end
        msalu_pkg::OP_LT: begin
          o.result_value = 32'(a < b); o.result_type = msalu_pkg::T_BOOL;
        end
        msalu_pkg::OP_LE: begin
          o.result_value = 32'(a <= b); o.result_type = msalu_pkg::T_BOOL;
        end
        msalu_pkg::OP_GT: begin
          o.result_value = 32'(a > b); o.result_type = msalu_pkg::T_BOOL;
        end
        msalu_pkg::OP_GE: begin
          o.result_value = 32'(a >= b); o.result_type = msalu_pkg::T_BOOL;
        end
        msalu_pkg::OP_ADD: o.result_value = a + b;
        msalu_pkg::OP_SUB: begin
          o.result_value = a - b;
          if (a < b) o.result_type = msalu_pkg::T_SGN;
        end
        msalu_pkg::OP_MUL: o.result_value = a * b;
        msalu_pkg::OP_DIV, msalu_pkg::OP_MOD: begin
          if (b == 0) begin
            o.result_type = msalu_pkg::T_ERR;
            o.error_code = 1'b1;
          end else o.result_value = (r.kind == msalu_pkg::OP_DIV) ? a / b : a % b;
        end
        msalu_pkg::OP_POW: begin
          acc = 32'd1;
          base = a;
          e = b;
          while (e != 0) begin
            if (e[0]) acc = acc * base;
            base = base * base;
            e = e >> 1;
          end
          o.result_value = acc;
        end
        msalu_pkg::OP_AND: o.result_value = a & b;
        msalu_pkg::OP_OR: o.result_value = a | b;
        msalu_pkg::OP_XOR: o.result_value = a ^ b;
        msalu_pkg::OP_SHL: o.result_value = (b >= WIDTH) ? '0 : a << b;
        msalu_pkg::OP_SHR: o.result_value = (b >= WIDTH) ? '0 : a >> b;
        default: ;
      endcase
    end else begin
      case (msalu_pkg::op_e'(r.kind))
        msalu_pkg::OP_CMP: o.result_value = 32'd1;
        msalu_pkg::OP_EQ, msalu_pkg::OP_LT, msalu_pkg::OP_LE:
          o.result_type = msalu_pkg::T_BOOL;
        msalu_pkg::OP_NE, msalu_pkg::OP_GT, msalu_pkg::OP_GE: begin
          o.result_value = 32'd1;
          o.result_type = msalu_pkg::T_BOOL;
        end
        msalu_pkg::OP_ADD: begin
          o.result_value = a + b;
          if (!(a > mag)) o.result_type = msalu_pkg::T_SGN;
        end
        msalu_pkg::OP_SUB: o.result_value = a - b;
        msalu_pkg::OP_MUL: begin
          o.result_value = a * b; o.result_type = msalu_pkg::T_SGN;
        end
        msalu_pkg::OP_DIV: begin
          o.result_value = -(a / mag); o.result_type = msalu_pkg::T_SGN;
        end
        msalu_pkg::OP_MOD: begin
          rem = a % mag;
          o.result_value = (rem == 0) ? '0 : rem + b;
          o.result_type = msalu_pkg::T_SGN;
        end
        msalu_pkg::OP_POW: begin
          if (a == 0) begin
            o.result_type = msalu_pkg::T_ERR;
            o.error_code = 1'b1;
          end else o.result_type = msalu_pkg::T_FLT;
        end
        msalu_pkg::OP_AND: o.result_value = a & b;
        msalu_pkg::OP_OR: o.result_value = a | b;
        msalu_pkg::OP_XOR: o.result_value = a ^ b;
        msalu_pkg::OP_SHL: o.result_value = (mag >= WIDTH) ? '0 : a >> mag;
        msalu_pkg::OP_SHR: o.result_value = (mag >= WIDTH) ? '0 : a << mag;
        default: ;
      endcase
    end
    return o;
  endfunction

  // send one transaction, waiting for acceptance; valid stays up afterwards
  task automatic send_request(msalu_pkg::req_t r, logic has_rsp,
                              msalu_pkg::rsp_t typed);
    while (($urandom_range(99) < send_idle_pct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(has_rsp ? typed : alu_result(r));
  endtask

  // random operand biased toward edges and small counts
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000 | $urandom_range(3);
      3: return $urandom_range(40);
      4: return -$urandom_range(40);
      5: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // receiver: stall randomly, check each result
  always @(posedge clk_i) begin
    msalu_pkg::rsp_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        result_count++;
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result %h", out_data_o);
        end else begin
          want = pending_results.pop_front();
          if (out_data_o.result_value !== want.result_value ||
              out_data_o.result_type !== want.result_type ||
              out_data_o.error_code !== want.error_code) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected %h/%0d/%0d got %h/%0d/%0d",
                       want.result_value, want.result_type, want.error_code,
                       out_data_o.result_value, out_data_o.result_type,
                       out_data_o.error_code);
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    row_t rows[$];
    msalu_pkg::req_t r;
    msalu_pkg::rsp_t none;
    int wait_cycles;
    none = '0;
    mismatch_count = 0;
    result_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    done_sending = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    rows.push_back('{'{msalu_pkg::OP_DIV, 32'd7, 32'd0, 1'b0}, 1'b1,
                     '{32'd0, msalu_pkg::T_ERR, 1'b1}});
    rows.push_back('{'{msalu_pkg::OP_MOD, 32'd7, 32'd0, 1'b1}, 1'b1,
                     '{32'd0, msalu_pkg::T_ERR, 1'b1}});
    rows.push_back('{'{msalu_pkg::OP_POW, 32'd0, 32'hffff_ffff, 1'b1}, 1'b1,
                     '{32'd0, msalu_pkg::T_ERR, 1'b1}});
    rows.push_back('{'{msalu_pkg::OP_POW, 32'd3, 32'hffff_fffe, 1'b1}, 1'b1,
                     '{32'd0, msalu_pkg::T_FLT, 1'b0}});
    rows.push_back('{'{msalu_pkg::OP_POW, 32'd0, 32'd0, 1'b0}, 1'b1,
                     '{32'd1, msalu_pkg::T_UNS, 1'b0}});
    rows.push_back('{'{5'd31, 32'hffff_ffff, 32'hffff_ffff, 1'b1}, 1'b1,
                     '{32'd0, msalu_pkg::T_ERR, 1'b0}});
    rows.push_back('{'{5'd18, 32'd0, 32'd0, 1'b0}, 1'b1,
                     '{32'd0, msalu_pkg::T_ERR, 1'b0}});
    rows.push_back('{'{msalu_pkg::OP_CMP, 32'd0, 32'hffff_ffff, 1'b0}, 1'b1,
                     '{32'hffff_ffff, msalu_pkg::T_SGN, 1'b0}});
    rows.push_back('{'{msalu_pkg::OP_SHL, 32'hffff_ffff, 32'd32, 1'b0}, 1'b1,
                     '{32'd0, msalu_pkg::T_UNS, 1'b0}});
    rows.push_back('{'{msalu_pkg::OP_SHR, 32'hffff_ffff, 32'hffff_ffe0, 1'b1}, 1'b1,
                     '{32'd0, msalu_pkg::T_UNS, 1'b0}});
    rows.push_back('{'{msalu_pkg::OP_MOD, 32'd8, 32'hffff_fffc, 1'b1}, 1'b0, none});
    rows.push_back('{'{msalu_pkg::OP_MOD, 32'd9, 32'hffff_fffc, 1'b1}, 1'b0, none});
    rows.push_back('{'{msalu_pkg::OP_DIV, 32'hffff_ffff, 32'h8000_0000, 1'b1}, 1'b0,
                     none});
    rows.push_back('{'{msalu_pkg::OP_ADD, 32'd5, 32'hffff_fffb, 1'b1}, 1'b0, none});
    rows.push_back('{'{msalu_pkg::OP_ADD, 32'd6, 32'hffff_fffb, 1'b1}, 1'b0, none});
    rows.push_back('{'{msalu_pkg::OP_SUB, 32'd1, 32'd2, 1'b0}, 1'b0, none});
    rows.push_back('{'{msalu_pkg::OP_MUL, 32'd3, 32'hffff_ffff, 1'b1}, 1'b0, none});
    rows.push_back('{'{msalu_pkg::OP_SHL, 32'd1, 32'd31, 1'b1}, 1'b0, none});
    rows.push_back('{'{msalu_pkg::OP_SHL, 32'h8000_0000, 32'hffff_ffe1, 1'b1}, 1'b0,
                     none});
    rows.push_back('{'{msalu_pkg::OP_POW, 32'hffff_ffff, 32'hffff_ffff, 1'b0}, 1'b0,
                     none});
    for (int k = msalu_pkg::OP_CMP; k <= msalu_pkg::OP_SHR; k++)
      if (k != msalu_pkg::OP_CMP && k <= msalu_pkg::OP_GE)
        rows.push_back('{'{k[4:0], 32'd4, 32'hffff_ffff, 1'b1}, 1'b0, none});
    foreach (rows[i]) send_request(rows[i].req, rows[i].has_rsp, rows[i].rsp);
    in_valid_i <= 1'b0;

    // drain fully before the random part
    while (pending_results.size() != 0) @(posedge clk_i);

    // random part over idling phases
    for (int i = 0; i < N_RANDOM; i++) begin
      case (i / (N_RANDOM / 4))
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 46; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 46; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      r.kind = ($urandom_range(19) == 0) ? 5'($urandom_range(31)) :
               5'($urandom_range(msalu_pkg::OP_SHR));
      r.left_operand = pick_operand();
      r.right_operand = pick_operand();
      r.right_is_signed = 1'($urandom_range(1));
      send_request(r, 1'b0, none);
    end
    in_valid_i <= 1'b0;
    done_sending = 1'b1;

    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (80) @(posedge clk_i);
    $display("checked %0d results from %0d directed and %0d random transactions",
             result_count, rows.size(), N_RANDOM);
    $display("covered all operators, sign modes, error cases and four idling mixes");
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count,
               pending_results.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
design/msalu_pkg.sv
design/msalu_ctrl.sv
design/msalu_dp.sv
design/unsigned_mixed_sign_alu.sv
verif/unsigned_mixed_sign_alu_test.sv
